// ----- design/etf_pkg.sv -----
// Shared types, constants and fixed-point helpers for the escape-time fractal lanes unit.
package etf_pkg;

    localparam int LANES     = 8;
    localparam int NUM_OUT   = 8;
    localparam int FRAC_BITS = 24;
    localparam int COUNT_W   = 8;
    localparam int POS_W     = 10;
    localparam int COL_W     = POS_W + 1;
    localparam int STEP_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN  = 3'd0,
        CFG_Y_ORIGIN  = 3'd1,
        CFG_STEP_SIZE = 3'd2,
        CFG_MAX_ITER  = 3'd3,
        CFG_ESCAPE_SQ = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMUL,
        S_CADD,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cmul;
        logic cadd;
        logic mul;
        logic upd;
    } t_lane_ctrl;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col_base;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] count_0;
        logic [COUNT_W-1:0] count_1;
        logic [COUNT_W-1:0] count_2;
        logic [COUNT_W-1:0] count_3;
        logic [COUNT_W-1:0] count_4;
        logic [COUNT_W-1:0] count_5;
        logic [COUNT_W-1:0] count_6;
        logic [COUNT_W-1:0] count_7;
    } t_out_word;

    function automatic logic signed [31:0] sat_s64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        ax = a;
        bx = b;
        return sat_s64(ax + bx);
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        ax = a;
        bx = b;
        return sat_s64(ax - bx);
    endfunction

    // floored product, shifted back to the fixed-point scale
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        logic signed [63:0] p;
        ax = a;
        bx = b;
        p  = ax * bx;
        return sat_s64(p >>> FRAC_BITS);
    endfunction

endpackage

// ----- design/etf_lane.sv -----
// One iteration lane: point setup, z squared products and the escape update.
module etf_lane
    import etf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_ctrl                i_ctrl,
    input  logic [COL_W-1:0]          i_col,
    input  logic [STEP_W-1:0]         i_step_size,
    input  logic signed [31:0]        i_x_origin,
    input  logic signed [31:0]        i_ci,
    input  logic [30:0]               i_escape_sq,
    output logic [COUNT_W-1:0]        o_count
);

    localparam int CPROD_W = COL_W + STEP_W;

    logic [CPROD_W-1:0]  r_cprod;
    logic signed [31:0]  r_cr;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic signed [31:0]  r_x2;
    logic signed [31:0]  r_y2;
    logic signed [31:0]  r_xy;
    logic [COUNT_W-1:0]  r_cnt;
    logic                r_esc;

    logic signed [31:0]  n_cr;
    logic signed [31:0]  n_x;
    logic signed [31:0]  n_y;
    logic signed [31:0]  d;
    logic signed [31:0]  esc_lim;
    logic                inside_r;
    logic signed [63:0]  org_x;
    logic signed [63:0]  prod_x;

    always_comb begin
        org_x    = i_x_origin;
        prod_x   = $signed({{(64-CPROD_W){1'b0}}, r_cprod});
        n_cr     = sat_s64(org_x + prod_x);
        d        = add_sat(r_x2, r_y2);
        esc_lim  = $signed({1'b0, i_escape_sq});
        inside_r = (d <= esc_lim);
        n_x      = add_sat(sub_sat(r_x2, r_y2), r_cr);
        n_y      = add_sat(add_sat(r_xy, r_xy), i_ci);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmul) begin
            r_cprod <= i_col * i_step_size;
        end
        if (i_ctrl.cadd) begin
            r_cr <= n_cr;
        end
        if (i_ctrl.mul) begin
            r_x2 <= fx_mul(r_x, r_x);
            r_y2 <= fx_mul(r_y, r_y);
            r_xy <= fx_mul(r_x, r_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_cnt <= '0;
            r_esc <= 1'b0;
        end else if (i_ctrl.cadd) begin
            r_x   <= '0;
            r_y   <= '0;
            r_cnt <= '0;
            r_esc <= 1'b0;
        end else if (i_ctrl.upd && !r_esc) begin
            if (inside_r) begin
                r_cnt <= r_cnt + 1'b1;
                r_x   <= n_x;
                r_y   <= n_y;
            end else begin
                r_esc <= 1'b1;
            end
        end
    end

    assign o_count = r_cnt;

`ifndef SYNTHESIS
    a_esc_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc && !i_ctrl.cadd |=> $stable(r_cnt) && r_esc)
        else $error("escaped lane changed its count");

    a_count_only_on_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.upd && !i_ctrl.cadd |=> $stable(r_cnt))
        else $error("lane count moved outside an update");

    a_cadd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.cadd |=> r_cnt == '0 && !r_esc)
        else $error("lane not cleared at point setup");
`endif

endmodule

// ----- design/etf_merge.sv -----
// Gathers the lane counts into one result word and holds it in the output register.
module etf_merge
    import etf_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ld,
    input  logic [LANES-1:0][COUNT_W-1:0]   i_counts,
    input  logic                            i_stall,
    output logic                            o_free,
    output logic                            o_valid,
    output t_out_word                       o_word
);

    logic [NUM_OUT-1:0][COUNT_W-1:0] full;
    t_out_word                       n_word;
    t_out_word                       r_word;
    logic                            r_valid;

    genvar j;
    generate
        for (j = 0; j < NUM_OUT; j++) begin : g_fill
            if (j < LANES) begin : g_lane
                assign full[j] = i_counts[j];
            end else begin : g_zero
                assign full[j] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_word.count_0 = full[0];
        n_word.count_1 = full[1];
        n_word.count_2 = full[2];
        n_word.count_3 = full[3];
        n_word.count_4 = full[4];
        n_word.count_5 = full[5];
        n_word.count_6 = full[6];
        n_word.count_7 = full[7];
    end

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |-> !i_ld)
        else $error("pending word overwritten");

    a_ld_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ld |=> r_valid && r_word == $past(n_word))
        else $error("loaded word not presented");

    a_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_word))
        else $error("stalled word lost");
`endif

endmodule

// ----- design/escape_time_fractal_lanes_unit.sv -----
// Top level: configuration registers, iteration sequencer, lanes and result merge.
//
//   channel   dir  handshake                   word
//   input     in   i_in_valid / o_in_stall     i_in_word  (row, col_base)
//   output    out  o_out_valid / i_out_stall   o_out_word (count_0..count_7)
//   config    in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// An item passes S_CMUL and S_CADD for setup, max_iter iterations, then S_DONE to hand over.
// Each iteration has two steps: the squaring multipliers, then the add/escape update.
// All lanes run in lock step, so an item runs the full iteration loop even once every lane has escaped.
// One item is in the lanes at a time; a finished word waits in the output register
// while the next item is taken. Reset is synchronous; it clears control and sets config defaults.
module escape_time_fractal_lanes_unit
    import etf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int RPROD_W = POS_W + STEP_W;

    logic signed [31:0]   r_x_origin;
    logic signed [31:0]   r_y_origin;
    logic [STEP_W-1:0]    r_step_size;
    logic [COUNT_W-1:0]   r_max_iter;
    logic [30:0]          r_escape_sq;

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_iter;
    logic [COUNT_W-1:0]   n_iter;
    logic [COUNT_W-1:0]   r_lim;
    logic [POS_W-1:0]     r_row;
    logic [POS_W-1:0]     r_col_base;
    logic [RPROD_W-1:0]   r_rprod;
    logic signed [31:0]   r_ci;
    logic signed [31:0]   n_ci;
    logic signed [63:0]   org_y;
    logic signed [63:0]   prod_y;

    t_lane_ctrl           lane_ctrl;
    logic                 in_acc;
    logic                 mrg_ld;
    logic                 mrg_free;
    logic [LANES-1:0][COUNT_W-1:0] counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin  <= -32'sd36909875;
            r_y_origin  <= -32'sd20132659;
            r_step_size <= 31'd67109;
            r_max_iter  <= 8'd200;
            r_escape_sq <= 31'd1677721600;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_X_ORIGIN:  r_x_origin  <= $signed(i_cfg_data);
                CFG_Y_ORIGIN:  r_y_origin  <= $signed(i_cfg_data);
                CFG_STEP_SIZE: r_step_size <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[COUNT_W-1:0];
                CFG_ESCAPE_SQ: r_escape_sq <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state        = r_state;
        n_iter         = r_iter;
        lane_ctrl      = '0;
        mrg_ld         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CMUL;
                end
            end
            S_CMUL: begin
                lane_ctrl.cmul = 1'b1;
                n_state        = S_CADD;
            end
            S_CADD: begin
                lane_ctrl.cadd = 1'b1;
                n_iter         = '0;
                n_state        = (r_lim == '0) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                lane_ctrl.mul = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                lane_ctrl.upd = 1'b1;
                n_iter        = r_iter + 1'b1;
                n_state       = (n_iter >= r_lim) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (mrg_free) begin
                    mrg_ld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        org_y  = r_y_origin;
        prod_y = $signed({{(64-RPROD_W){1'b0}}, r_rprod});
        n_ci   = sat_s64(org_y + prod_y);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row      <= i_in_word.row;
            r_col_base <= i_in_word.col_base;
            r_lim      <= r_max_iter;
        end
        if (lane_ctrl.cmul) begin
            r_rprod <= r_row * r_step_size;
        end
        if (lane_ctrl.cadd) begin
            r_ci <= n_ci;
        end
    end

    genvar k;
    generate
        for (k = 0; k < LANES; k++) begin : g_lane
            logic [COL_W-1:0] lane_col;
            assign lane_col = COL_W'(r_col_base) + COL_W'(k);

            etf_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (lane_ctrl),
                .i_col       (lane_col),
                .i_step_size (r_step_size),
                .i_x_origin  (r_x_origin),
                .i_ci        (r_ci),
                .i_escape_sq (r_escape_sq),
                .o_count     (counts[k])
            );
        end
    endgenerate

    etf_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (mrg_ld),
        .i_counts (counts),
        .i_stall  (i_out_stall),
        .o_free   (mrg_free),
        .o_valid  (o_out_valid),
        .o_word   (o_out_word)
    );

`ifndef SYNTHESIS
    a_iter_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_UPD) |-> r_iter < r_lim)
        else $error("iteration counter past limit");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_CMUL)
        else $error("accepted word did not start setup");

    a_done_only_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD && n_state == S_DONE |-> 8'(r_iter + 1'b1) == r_lim)
        else $error("iteration stopped early");
`endif

endmodule

// ----- tb/sv/escape_time_fractal_lanes_unit_tb.sv -----
// Testbench for the escape-time fractal lanes unit, checked against a local predictor.
module escape_time_fractal_lanes_unit_tb;
    import etf_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int ESC_W         = 31;
    localparam int MAX_GAP       = 15;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 3 + 2 * 255 + 1;
    localparam int MAX_PRINTS    = 40;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 124;
    localparam int IDLE_STRETCH  = 40;
    localparam int RUN_LIMIT     = 4_000_000;

    localparam logic [31:0]         X_ORIGIN_RST  = -32'sd36909875;
    localparam logic [31:0]         Y_ORIGIN_RST  = -32'sd20132659;
    localparam logic [STEP_W-1:0]   STEP_RST      = 31'd67109;
    localparam logic [COUNT_W-1:0]  MAX_ITER_RST  = 8'd200;
    localparam logic [ESC_W-1:0]    ESCAPE_SQ_RST = 31'd1677721600;
    localparam logic [ESC_W-1:0]    RADIUS_TWO_SQ = 31'd67108864;
    localparam int                  X_EDGE        = -12582912;
    localparam int                  Y_EDGE        = 1677722;

    typedef enum int {
        VIEW_WIDE,
        VIEW_FAR,
        VIEW_ANY,
        VIEW_EDGE
    } t_view;

    typedef struct {
        t_in_word  pixel;
        t_out_word counts;
    } t_due;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    // register copies for the predictor
    logic signed [31:0]    m_x_origin;
    logic signed [31:0]    m_y_origin;
    logic [STEP_W-1:0]     m_step;
    logic [COUNT_W-1:0]    m_max_iter;
    logic [ESC_W-1:0]      m_escape_sq;

    t_due                  counts_due[$];
    int                    errors      = 0;
    int                    sink_wait   = 0;
    bit                    src_idle    = 1'b1;
    bit                    sink_idle   = 1'b1;
    logic                  hold_active = 1'b0;
    event                  hold_start;

    escape_time_fractal_lanes_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // floored fixed-point product
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic logic [COUNT_W-1:0] escape_count(input logic signed [31:0] cr,
                                                        input logic signed [31:0] ci);
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] rr;
        logic signed [31:0] ii;
        logic signed [31:0] ri;
        logic signed [31:0] mag;
        logic [COUNT_W-1:0] cnt;
        int                 n;
        zr  = '0;
        zi  = '0;
        cnt = '0;
        for (n = 0; n < int'(m_max_iter); n++) begin
            rr  = qmul(zr, zr);
            ii  = qmul(zi, zi);
            ri  = qmul(zr, zi);
            mag = clamp32(longint'(rr) + longint'(ii));
            if (longint'(mag) > longint'(m_escape_sq)) begin
                break;
            end
            cnt++;
            zr = clamp32(longint'(clamp32(longint'(rr) - longint'(ii))) + longint'(cr));
            zi = clamp32(longint'(clamp32(longint'(ri) + longint'(ri))) + longint'(ci));
        end
        return cnt;
    endfunction

    function automatic t_out_word predict_counts(input t_in_word px);
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        t_out_word          w;
        int                 k;
        w  = '0;
        ci = clamp32(longint'(m_y_origin) + longint'(px.row) * longint'(m_step));
        for (k = 0; k < LANES; k++) begin
            cr = clamp32(longint'(m_x_origin)
                         + (longint'(px.col_base) + k) * longint'(m_step));
            w[(NUM_OUT-1-k)*COUNT_W +: COUNT_W] = escape_count(cr, ci);
        end
        return w;
    endfunction

    function automatic t_in_word pixel_at(input int r, input int c);
        t_in_word px;
        px.row      = r[POS_W-1:0];
        px.col_base = c[POS_W-1:0];
        return px;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        errors++;
    endtask

    task automatic take_counts(input t_out_word got);
        t_due               due;
        int                 k;
        logic [COUNT_W-1:0] g;
        logic [COUNT_W-1:0] e;
        if (counts_due.size() == 0) begin
            report_mismatch($sformatf("word %h with nothing outstanding", got));
        end else begin
            due = counts_due.pop_front();
            for (k = 0; k < NUM_OUT; k++) begin
                g = got[(NUM_OUT-1-k)*COUNT_W +: COUNT_W];
                e = due.counts[(NUM_OUT-1-k)*COUNT_W +: COUNT_W];
                if (g !== e) begin
                    report_mismatch($sformatf("row %0d col %0d count_%0d: got %0d, want %0d",
                                              due.pixel.row, due.pixel.col_base, k, g, e));
                end
            end
        end
    endtask

    task automatic send_pixel(input t_in_word px);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= px;
        do @(posedge clk); while (in_stall);
        counts_due.push_back('{pixel: px, counts: predict_counts(px)});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_X_ORIGIN:  m_x_origin  = data;
            CFG_Y_ORIGIN:  m_y_origin  = data;
            CFG_STEP_SIZE: m_step      = data[STEP_W-1:0];
            CFG_MAX_ITER:  m_max_iter  = data[COUNT_W-1:0];
            CFG_ESCAPE_SQ: m_escape_sq = data[ESC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle(input int cycles);
        in_valid <= 1'b0;
        while (counts_due.size() != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic default_view();
        write_reg(CFG_X_ORIGIN, X_ORIGIN_RST);
        write_reg(CFG_Y_ORIGIN, Y_ORIGIN_RST);
        write_reg(CFG_STEP_SIZE, CFG_DAT_W'(STEP_RST));
        write_reg(CFG_ESCAPE_SQ, CFG_DAT_W'(ESCAPE_SQ_RST));
    endtask

    // registers as left by reset; centre of the set, and groups ending at and running past column 1023
    task automatic test_reset_view();
        send_pixel(pixel_at(0, 0));
        send_pixel(pixel_at(300, 550));
        send_pixel(pixel_at(1023, 1016));
        send_pixel(pixel_at(1023, 1023));
        settle(SETTLE_CYCLES);
    endtask

    task automatic test_field_extremes();
        write_reg(CFG_X_ORIGIN, 32'h8000_0000);
        write_reg(CFG_Y_ORIGIN, 32'h7fff_ffff);
        write_reg(CFG_STEP_SIZE, 32'h7fff_ffff);
        write_reg(CFG_MAX_ITER, 32'd255);
        write_reg(CFG_ESCAPE_SQ, 32'h7fff_ffff);
        send_pixel(pixel_at(0, 0));
        send_pixel(pixel_at(1023, 1023));
        send_pixel(pixel_at(0, 1023));
        send_pixel(pixel_at(1023, 0));
        settle(SETTLE_CYCLES);
        // zero point, zero radius: z stays at the origin for every iteration
        write_reg(CFG_X_ORIGIN, 32'd0);
        write_reg(CFG_Y_ORIGIN, 32'd0);
        write_reg(CFG_STEP_SIZE, 32'd0);
        write_reg(CFG_ESCAPE_SQ, 32'd0);
        send_pixel(pixel_at(0, 0));
        send_pixel(pixel_at(1023, 1023));
        settle(SETTLE_CYCLES);
        write_reg(CFG_MAX_ITER, 32'd1);
        write_reg(CFG_STEP_SIZE, 32'd1);
        send_pixel(pixel_at(512, 512));
        settle(SETTLE_CYCLES);
    endtask

    task automatic test_zero_limit();
        default_view();
        write_reg(CFG_MAX_ITER, 32'd0);
        send_pixel(pixel_at(300, 550));
        send_pixel(pixel_at($urandom_range(0, 1023), $urandom_range(0, 1023)));
        settle(SETTLE_CYCLES);
    endtask

    // writes above the last register index must leave the view alone
    task automatic test_unknown_index();
        int i;
        write_reg(CFG_MAX_ITER, 32'd16);
        for (i = int'(CFG_ESCAPE_SQ) + 1; i < 2 ** CFG_IDX_W; i++) begin
            write_reg(i[CFG_IDX_W-1:0], $urandom);
        end
        send_pixel(pixel_at(300, 550));
        send_pixel(pixel_at(250, 400));
        settle(SETTLE_CYCLES);
    endtask

    // sink holds off while words keep coming, so the input side must stall
    task automatic test_output_hold();
        int i;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        -> hold_start;
        for (i = 0; i < 8; i++) begin
            send_pixel(pixel_at($urandom_range(0, 1023), $urandom_range(0, 1023)));
        end
        settle(SETTLE_CYCLES);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_views();
        int    ph;
        int    i;
        t_view kind;
        for (ph = 0; ph < PHASES; ph++) begin
            kind = t_view'($urandom_range(0, 3));
            case (kind)
                VIEW_WIDE, VIEW_FAR: begin
                    write_reg(CFG_X_ORIGIN, X_ORIGIN_RST + $urandom_range(0, 1 << 25) - (1 << 24));
                    write_reg(CFG_Y_ORIGIN, Y_ORIGIN_RST + $urandom_range(0, 1 << 25) - (1 << 24));
                    write_reg(CFG_STEP_SIZE, $urandom_range(1, 200000));
                    write_reg(CFG_ESCAPE_SQ,
                              CFG_DAT_W'((kind == VIEW_WIDE) ? RADIUS_TWO_SQ : ESCAPE_SQ_RST));
                end
                VIEW_EDGE: begin
                    write_reg(CFG_X_ORIGIN, X_EDGE + $urandom_range(0, 1 << 21) - (1 << 20));
                    write_reg(CFG_Y_ORIGIN, Y_EDGE + $urandom_range(0, 1 << 21) - (1 << 20));
                    write_reg(CFG_STEP_SIZE, $urandom_range(1, 256));
                    write_reg(CFG_ESCAPE_SQ, CFG_DAT_W'(RADIUS_TWO_SQ));
                end
                default: begin
                    write_reg(CFG_X_ORIGIN, $urandom);
                    write_reg(CFG_Y_ORIGIN, $urandom);
                    write_reg(CFG_STEP_SIZE, $urandom);
                    write_reg(CFG_ESCAPE_SQ, $urandom);
                end
            endcase
            write_reg(CFG_MAX_ITER, ($urandom_range(0, 3) == 0) ? $urandom_range(200, 255)
                                                                 : $urandom_range(1, 120));
            for (i = 0; i < PHASE_WORDS; i++) begin
                if (i % IDLE_STRETCH == 0) begin
                    src_idle  = $urandom_range(0, 2) != 0;
                    sink_idle = $urandom_range(0, 2) != 0;
                end
                send_pixel(pixel_at($urandom_range(0, 1023), $urandom_range(0, 1023)));
            end
            settle(SETTLE_CYCLES);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            take_counts(out_word);
            sink_wait = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (sink_wait == 0 && sink_idle && $urandom_range(0, 31) == 0) begin
            sink_wait = $urandom_range(1, MAX_GAP);
        end
        if (hold_active) begin
            out_stall <= 1'b1;
        end else if (sink_wait > 0) begin
            out_stall <= 1'b1;
            sink_wait--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        forever begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    initial begin
        #(CLK_PERIOD * RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        m_x_origin  = X_ORIGIN_RST;
        m_y_origin  = Y_ORIGIN_RST;
        m_step      = STEP_RST;
        m_max_iter  = MAX_ITER_RST;
        m_escape_sq = ESCAPE_SQ_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_view();
        test_field_extremes();
        test_zero_limit();
        test_unknown_index();
        test_output_hold();
        test_random_views();
        settle(TAIL_CYCLES);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/etf_pkg.sv
design/etf_lane.sv
design/etf_merge.sv
design/escape_time_fractal_lanes_unit.sv
tb/sv/escape_time_fractal_lanes_unit_tb.sv
